FILE: design/nld_pkg.sv
// ----------------------------------------------------------------------------
// nld_pkg
// Shared types, codes and constants of the neighbour location derivation core.
// ----------------------------------------------------------------------------
package nld_pkg;

	// Field widths fixed by the interface
	localparam int CUR_W  = 16;
	localparam int LOC_W  = 6;
	localparam int ADDR_W = 16;
	localparam int KIND_W = 3;
	localparam int PICW_W = 9;
	localparam int CHRW_W = 5;

	// Configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Column remainder: bits of the address consumed per pipeline stage
	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = CUR_W / BITS_PER_STAGE;

	// Frame size limit and default picture width limit
	localparam int MAX_FRAME_MBS = 65536;
	localparam int MAX_WIDTH_MBS = 256;

	// Register reset values
	localparam logic [PICW_W-1:0] PIC_WIDTH_RST = 9'd1;
	localparam logic [CHRW_W-1:0] CHROMA_RST    = 5'd8;

	// Register indexes
	typedef enum logic [1:0] {
		REG_PIC_WIDTH = 2'd0,
		REG_CHROMA_W  = 2'd1,
		REG_CHROMA_H  = 2'd2
	} reg_idx_t;

	// Neighbour kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_CUR  = 3'd0,
		KIND_A    = 3'd1,
		KIND_B    = 3'd2,
		KIND_C    = 3'd3,
		KIND_D    = 3'd4,
		KIND_NONE = 3'd5
	} nb_kind_t;

	// One input item as it moves down the pipeline
	typedef struct packed {
		logic [CUR_W-1:0]        cur_mb_addr;
		logic signed [LOC_W-1:0] loc_x;
		logic signed [LOC_W-1:0] loc_y;
		logic                    is_luma;
	} item_t;

	// Configuration register contents
	typedef struct packed {
		logic [PICW_W-1:0] pic_width_mbs;
		logic [CHRW_W-1:0] chroma_mb_width;
		logic [CHRW_W-1:0] chroma_mb_height;
	} cfg_t;

endpackage

FILE: design/nld_cfg_regs.sv
// ----------------------------------------------------------------------------
// nld_cfg_regs
// APB register file; also derives the effective picture width.
// ----------------------------------------------------------------------------
module nld_cfg_regs #(
	parameter int MAX_WIDTH_MBS = nld_pkg::MAX_WIDTH_MBS,
	parameter int WIDTH_W       = $clog2(MAX_WIDTH_MBS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nld_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nld_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nld_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output nld_pkg::cfg_t                     cfg,
	output logic [WIDTH_W-1:0]                eff_width
);

	localparam logic [10:0] WIDTH_LIMIT = 11'(MAX_WIDTH_MBS);

	nld_pkg::cfg_t    cfg_q;
	nld_pkg::reg_idx_t idx;
	logic             wr_en;
	logic [10:0]      pic_ext;
	logic [10:0]      pic_fix;

	assign pready = 1'b1;
	assign idx    = nld_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pic_width_mbs    <= nld_pkg::PIC_WIDTH_RST;
			cfg_q.chroma_mb_width  <= nld_pkg::CHROMA_RST;
			cfg_q.chroma_mb_height <= nld_pkg::CHROMA_RST;
		end else if (wr_en) begin
			unique case (idx)
				nld_pkg::REG_PIC_WIDTH: cfg_q.pic_width_mbs <= pwdata[nld_pkg::PICW_W-1:0];
				nld_pkg::REG_CHROMA_W:  cfg_q.chroma_mb_width <= pwdata[nld_pkg::CHRW_W-1:0];
				nld_pkg::REG_CHROMA_H:  cfg_q.chroma_mb_height <= pwdata[nld_pkg::CHRW_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			nld_pkg::REG_PIC_WIDTH: prdata = 32'(cfg_q.pic_width_mbs);
			nld_pkg::REG_CHROMA_W:  prdata = 32'(cfg_q.chroma_mb_width);
			nld_pkg::REG_CHROMA_H:  prdata = 32'(cfg_q.chroma_mb_height);
			default:                prdata = '0;
		endcase
	end

	// Zero width counts as one, clamp to the supported maximum
	always_comb begin
		pic_ext = 11'(cfg_q.pic_width_mbs);
		if (pic_ext == 11'd0)
			pic_fix = 11'd1;
		else if (pic_ext > WIDTH_LIMIT)
			pic_fix = WIDTH_LIMIT;
		else
			pic_fix = pic_ext;
		eff_width = pic_fix[WIDTH_W-1:0];
	end

endmodule

FILE: design/nld_div_step.sv
// ----------------------------------------------------------------------------
// nld_div_step
// Restoring remainder steps: folds a few address bits into the column
// remainder modulo the picture width.
// ----------------------------------------------------------------------------
module nld_div_step #(
	parameter int WIDTH_W = 9,
	parameter int BPS     = nld_pkg::BITS_PER_STAGE
) (
	input  logic [WIDTH_W-1:0] rem_in,
	input  logic [BPS-1:0]     bits,
	input  logic [WIDTH_W-1:0] width,
	output logic [WIDTH_W-1:0] rem_out
);

	logic [WIDTH_W:0]   trial;
	logic [WIDTH_W-1:0] rem;

	// Shift in one bit at a time, subtract width when it fits
	always_comb begin
		rem   = rem_in;
		trial = '0;
		for (int j = 0; j < BPS; j++) begin
			trial = {rem, bits[BPS-1-j]};
			if (trial >= {1'b0, width})
				trial = trial - {1'b0, width};
			rem = trial[WIDTH_W-1:0];
		end
		rem_out = rem;
	end

endmodule

FILE: design/nld_select.sv
// ----------------------------------------------------------------------------
// nld_select
// Neighbour availability, Table 6-3 selection, location wrap and the
// output register.
// ----------------------------------------------------------------------------
module nld_select #(
	parameter int WIDTH_W = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	input  nld_pkg::item_t                item,
	input  logic [WIDTH_W-1:0]            col,
	input  logic [WIDTH_W-1:0]            width,
	input  nld_pkg::cfg_t                 cfg,
	input  logic                          out_stall,
	output logic                          take,
	output logic                          out_valid,
	output logic                          nb_available,
	output logic [nld_pkg::ADDR_W-1:0]    nb_addr,
	output logic [nld_pkg::KIND_W-1:0]    nb_kind,
	output logic [3:0]                    wrapped_x,
	output logic [3:0]                    wrapped_y
);

	localparam logic [16:0] FRAME_LIMIT = 17'(nld_pkg::MAX_FRAME_MBS);

	logic [16:0]                 cur17;
	logic [16:0]                 w17;
	logic [nld_pkg::ADDR_W-1:0]  cur;
	logic [nld_pkg::ADDR_W-1:0]  w16;
	logic                        left_col, right_col;
	logic                        av_a, av_b, av_c, av_d;
	logic [3:0]                  mask_x, mask_y;
	logic                        x_neg, x_in, x_big, y_neg, y_in;
	nld_pkg::nb_kind_t           kind;
	logic                        avail;
	logic [nld_pkg::ADDR_W-1:0]  addr;

	logic                        out_valid_q;
	logic                        avail_q;
	logic [nld_pkg::ADDR_W-1:0]  addr_q;
	nld_pkg::nb_kind_t           kind_q;
	logic [3:0]                  wx_q, wy_q;

	// Neighbour addresses and availability
	always_comb begin
		cur       = item.cur_mb_addr;
		cur17     = {1'b0, cur};
		w17       = 17'(width);
		w16       = 16'(width);
		left_col  = (col == '0);
		right_col = (col == width - WIDTH_W'(1));
		av_a      = (cur != '0) && !left_col;
		av_b      = (cur17 >= w17);
		av_c      = ((cur17 + 17'd1) >= w17) && !right_col;
		av_d      = (cur17 >= (w17 + 17'd1)) && !left_col;
	end

	// Classify the location against the block size
	always_comb begin
		mask_x = (item.is_luma || cfg.chroma_mb_width[4])  ? 4'hF : 4'h7;
		mask_y = (item.is_luma || cfg.chroma_mb_height[4]) ? 4'hF : 4'h7;
		x_neg  = item.loc_x[nld_pkg::LOC_W-1];
		y_neg  = item.loc_y[nld_pkg::LOC_W-1];
		x_in   = !x_neg && (item.loc_x[4:0] <= {1'b0, mask_x});
		y_in   = !y_neg && (item.loc_y[4:0] <= {1'b0, mask_y});
		x_big  = !x_neg && !x_in;
	end

	// Pick the macroblock that covers the location
	always_comb begin
		kind  = nld_pkg::KIND_NONE;
		avail = 1'b0;
		addr  = '0;
		if (x_neg && y_neg) begin
			kind  = nld_pkg::KIND_D;
			avail = av_d;
			addr  = cur - w16 - 16'd1;
		end else if (x_neg && y_in) begin
			kind  = nld_pkg::KIND_A;
			avail = av_a;
			addr  = cur - 16'd1;
		end else if (x_in && y_neg) begin
			kind  = nld_pkg::KIND_B;
			avail = av_b;
			addr  = cur - w16;
		end else if (x_in && y_in) begin
			kind  = nld_pkg::KIND_CUR;
			avail = 1'b1;
			addr  = cur;
		end else if (x_big && y_neg) begin
			kind  = nld_pkg::KIND_C;
			avail = av_c;
			addr  = cur - w16 + 16'd1;
		end
		if (cur17 >= FRAME_LIMIT) begin
			kind  = nld_pkg::KIND_NONE;
			avail = 1'b0;
		end
		if (!avail)
			addr = '0;
	end

	// Output register: load when empty or when the item is taken
	assign take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (take && valid_in) begin
			avail_q <= avail;
			addr_q  <= addr;
			kind_q  <= kind;
			wx_q    <= item.loc_x[3:0] & mask_x;
			wy_q    <= item.loc_y[3:0] & mask_y;
		end
	end

	assign out_valid    = out_valid_q;
	assign nb_available = avail_q;
	assign nb_addr      = addr_q;
	assign nb_kind      = kind_q;
	assign wrapped_x    = wx_q;
	assign wrapped_y    = wy_q;

endmodule

FILE: design/neighbour_location_derivation_core.sv
// ----------------------------------------------------------------------------
// neighbour_location_derivation_core
// Neighbouring macroblock and location derivation for non-MBAFF pictures.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  cur_mb_addr loc_x loc_y is_luma
//   out       output     out_valid/out_stall  nb_available nb_addr nb_kind
//                                             wrapped_x wrapped_y
//   cfg       input      APB write/read       pic_width_mbs chroma_mb_width
//                                             chroma_mb_height
//
// One item per cycle while out_stall is low; out_valid is registered after s4.
// Four stages each fold four address bits into the column
// remainder modulo the picture width; a fifth stage selects and wraps.
// Reset clears valid bits and restores the registers; there is no clearing
// pass. A stall holds every stage that is full; empty stages keep filling.
// ----------------------------------------------------------------------------
module neighbour_location_derivation_core #(
	parameter int MAX_WIDTH_MBS = nld_pkg::MAX_WIDTH_MBS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nld_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nld_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nld_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [nld_pkg::CUR_W-1:0]         cur_mb_addr,
	input  logic signed [nld_pkg::LOC_W-1:0]  loc_x,
	input  logic signed [nld_pkg::LOC_W-1:0]  loc_y,
	input  logic                              is_luma,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              nb_available,
	output logic [nld_pkg::ADDR_W-1:0]        nb_addr,
	output logic [nld_pkg::KIND_W-1:0]        nb_kind,
	output logic [3:0]                        wrapped_x,
	output logic [3:0]                        wrapped_y
);

	localparam int WIDTH_W = $clog2(MAX_WIDTH_MBS + 1);
	localparam int BPS     = nld_pkg::BITS_PER_STAGE;
	localparam int CW      = nld_pkg::CUR_W;

	nld_pkg::cfg_t      cfg;
	logic [WIDTH_W-1:0] width;
	nld_pkg::item_t     item_in;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	nld_pkg::item_t     item_s1, item_s2, item_s3, item_s4;
	logic [WIDTH_W-1:0] rem_s1, rem_s2, rem_s3, rem_s4;
	logic [WIDTH_W-1:0] rem_n1, rem_n2, rem_n3, rem_n4;
	logic               en1, en2, en3, en4, en5;

	nld_cfg_regs #(
		.MAX_WIDTH_MBS (MAX_WIDTH_MBS),
		.WIDTH_W       (WIDTH_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.eff_width (width)
	);

	assign item_in.cur_mb_addr = cur_mb_addr;
	assign item_in.loc_x       = loc_x;
	assign item_in.loc_y       = loc_y;
	assign item_in.is_luma     = is_luma;

	// Remainder steps, most significant address bits first
	nld_div_step #(.WIDTH_W(WIDTH_W), .BPS(BPS)) u_step1 (
		.rem_in  ('0),
		.bits    (cur_mb_addr[CW-1 -: BPS]),
		.width   (width),
		.rem_out (rem_n1)
	);
	nld_div_step #(.WIDTH_W(WIDTH_W), .BPS(BPS)) u_step2 (
		.rem_in  (rem_s1),
		.bits    (item_s1.cur_mb_addr[CW-1-BPS -: BPS]),
		.width   (width),
		.rem_out (rem_n2)
	);
	nld_div_step #(.WIDTH_W(WIDTH_W), .BPS(BPS)) u_step3 (
		.rem_in  (rem_s2),
		.bits    (item_s2.cur_mb_addr[CW-1-2*BPS -: BPS]),
		.width   (width),
		.rem_out (rem_n3)
	);
	nld_div_step #(.WIDTH_W(WIDTH_W), .BPS(BPS)) u_step4 (
		.rem_in  (rem_s3),
		.bits    (item_s3.cur_mb_addr[CW-1-3*BPS -: BPS]),
		.width   (width),
		.rem_out (rem_n4)
	);

	// Advance a stage when it is empty or the next one advances
	assign en4      = !valid_s4 || en5;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// Payload moves with its valid bit
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			item_s1 <= item_in;
			rem_s1  <= rem_n1;
		end
		if (en2 && valid_s1) begin
			item_s2 <= item_s1;
			rem_s2  <= rem_n2;
		end
		if (en3 && valid_s2) begin
			item_s3 <= item_s2;
			rem_s3  <= rem_n3;
		end
		if (en4 && valid_s3) begin
			item_s4 <= item_s3;
			rem_s4  <= rem_n4;
		end
	end

	nld_select #(.WIDTH_W(WIDTH_W)) u_sel (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_s4),
		.item         (item_s4),
		.col          (rem_s4),
		.width        (width),
		.cfg          (cfg),
		.out_stall    (out_stall),
		.take         (en5),
		.out_valid    (out_valid),
		.nb_available (nb_available),
		.nb_addr      (nb_addr),
		.nb_kind      (nb_kind),
		.wrapped_x    (wrapped_x),
		.wrapped_y    (wrapped_y)
	);

endmodule

FILE: design/nld_checker.sv
// ----------------------------------------------------------------------------
// nld_checker
// Port-level checks on the result channel of the core.
// ----------------------------------------------------------------------------
module nld_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              nb_available,
	input logic [nld_pkg::ADDR_W-1:0]        nb_addr,
	input logic [nld_pkg::KIND_W-1:0]        nb_kind,
	input logic [3:0]                        wrapped_x,
	input logic [3:0]                        wrapped_y
);

	// A held item keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nb_addr) && $stable(nb_kind)
			&& $stable(nb_available) && $stable(wrapped_x) && $stable(wrapped_y))
		else $error("result changed while stalled");

	// Unavailable neighbours report address zero
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !nb_available |-> nb_addr == '0)
		else $error("address given for unavailable neighbour");

	// The current macroblock is always available
	a_cur_avail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nb_kind == nld_pkg::KIND_CUR |-> nb_available)
		else $error("current macroblock reported unavailable");

	// No macroblock means not available
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nb_kind == nld_pkg::KIND_NONE |-> !nb_available)
		else $error("missing macroblock reported available");

endmodule

bind neighbour_location_derivation_core nld_checker u_nld_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the neighbour location derivation core. A short
// table of hand-picked lookups runs at the reset register values. Random
// lookups then run under a series of register settings, from the narrowest to
// the widest picture and all chroma sizes. Each result is compared with a
// behavioral derivation of the neighbour, while both channels idle in bursts.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY        = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 215;

	// Expected content of one result item
	typedef struct packed {
		logic                       avail;
		logic [nld_pkg::ADDR_W-1:0] addr;
		nld_pkg::nb_kind_t          kind;
		logic [3:0]                 wx;
		logic [3:0]                 wy;
	} nb_result_t;

	// One row of the hand-picked lookups; the result is used only when typed is set
	typedef struct {
		int                cur;
		int                x;
		int                y;
		bit                luma;
		bit                typed;
		bit                avail;
		int                addr;
		nld_pkg::nb_kind_t kind;
		int                wx;
		int                wy;
	} probe_row_t;

	// Rows at reset: one-macroblock-wide picture, 8x8 chroma
	probe_row_t probe_rows [24] = '{
		'{0,     0,   0,   1, 1, 1, 0,     nld_pkg::KIND_CUR,  0,  0},
		'{0,     15,  15,  1, 1, 1, 0,     nld_pkg::KIND_CUR,  15, 15},
		'{0,     -1,  -1,  1, 1, 0, 0,     nld_pkg::KIND_D,    15, 15},
		'{0,     -1,  0,   1, 1, 0, 0,     nld_pkg::KIND_A,    15, 0},
		'{0,     0,   -1,  1, 1, 0, 0,     nld_pkg::KIND_B,    0,  15},
		'{7,     5,   -1,  1, 1, 1, 6,     nld_pkg::KIND_B,    5,  15},
		'{7,     16,  -1,  1, 1, 0, 0,     nld_pkg::KIND_C,    0,  15},
		'{7,     16,  0,   1, 1, 0, 0,     nld_pkg::KIND_NONE, 0,  0},
		'{7,     0,   16,  1, 1, 0, 0,     nld_pkg::KIND_NONE, 0,  0},
		'{7,     -1,  16,  1, 1, 0, 0,     nld_pkg::KIND_NONE, 15, 0},
		'{7,     16,  16,  1, 1, 0, 0,     nld_pkg::KIND_NONE, 0,  0},
		'{65535, 0,   0,   1, 1, 1, 65535, nld_pkg::KIND_CUR,  0,  0},
		'{65535, 3,   -1,  1, 1, 1, 65534, nld_pkg::KIND_B,    3,  15},
		'{3,     7,   7,   0, 1, 1, 3,     nld_pkg::KIND_CUR,  7,  7},
		'{3,     8,   0,   0, 1, 0, 0,     nld_pkg::KIND_NONE, 0,  0},
		'{3,     8,   -1,  0, 1, 0, 0,     nld_pkg::KIND_C,    0,  7},
		'{3,     -1,  8,   0, 1, 0, 0,     nld_pkg::KIND_NONE, 7,  0},
		'{3,     -32, 31,  1, 1, 0, 0,     nld_pkg::KIND_NONE, 0,  15},
		'{3,     31,  -32, 1, 1, 0, 0,     nld_pkg::KIND_C,    15, 0},
		'{3,     -32, -32, 0, 1, 0, 0,     nld_pkg::KIND_D,    0,  0},
		'{3,     31,  31,  0, 1, 0, 0,     nld_pkg::KIND_NONE, 7,  7},
		'{3,     -1,  5,   0, 1, 0, 0,     nld_pkg::KIND_A,    7,  5},
		'{42,    21,  -11, 1, 0, 0, 0,     nld_pkg::KIND_NONE, 0,  0},
		'{1234,  -7,  9,   0, 0, 0, 0,     nld_pkg::KIND_NONE, 0,  0}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [nld_pkg::APB_ADDR_W-1:0]   paddr;
	logic [nld_pkg::APB_DATA_W-1:0]   pwdata;
	logic [nld_pkg::APB_DATA_W-1:0]   prdata;
	logic                             pready;
	logic                             in_valid;
	logic                             in_stall;
	logic [nld_pkg::CUR_W-1:0]        cur_mb_addr;
	logic signed [nld_pkg::LOC_W-1:0] loc_x;
	logic signed [nld_pkg::LOC_W-1:0] loc_y;
	logic                             is_luma;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             nb_available;
	logic [nld_pkg::ADDR_W-1:0]       nb_addr;
	logic [nld_pkg::KIND_W-1:0]       nb_kind;
	logic [3:0]                       wrapped_x;
	logic [3:0]                       wrapped_y;

	nld_pkg::cfg_t shadow_cfg;
	nb_result_t    neighbour_q [$];
	int            idle_pct;
	int            stall_left;
	int            quiet_cycles;
	int            mismatches;
	int            items_sent;
	int            results_seen;
	int            settings_used;

	neighbour_location_derivation_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cur_mb_addr  (cur_mb_addr),
		.loc_x        (loc_x),
		.loc_y        (loc_y),
		.is_luma      (is_luma),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.nb_available (nb_available),
		.nb_addr      (nb_addr),
		.nb_kind      (nb_kind),
		.wrapped_x    (wrapped_x),
		.wrapped_y    (wrapped_y)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Clamp the programmed width the way the block does
	function automatic int eff_width(input nld_pkg::cfg_t c);
		int w;
		w = c.pic_width_mbs;
		if (w == 0) w = 1;
		if (w > nld_pkg::MAX_WIDTH_MBS) w = nld_pkg::MAX_WIDTH_MBS;
		return w;
	endfunction

	// Derive the neighbouring macroblock and the wrapped location for one lookup
	function automatic nb_result_t derive_neighbour(input logic [nld_pkg::CUR_W-1:0] cur,
			input logic signed [nld_pkg::LOC_W-1:0] x,
			input logic signed [nld_pkg::LOC_W-1:0] y,
			input logic luma, input nld_pkg::cfg_t c);
		nb_result_t r;
		int  w, col, cur_i, xs, ys, mw, mh, a_a, a_b, a_c, a_d, sel_addr;
		bit  left_col, right_col, av_a, av_b, av_c, av_d, x_in, y_in;
		w = eff_width(c);
		cur_i = cur;
		xs = x;
		ys = y;
		mw = luma ? 16 : (c.chroma_mb_width[4] ? 16 : 8);
		mh = luma ? 16 : (c.chroma_mb_height[4] ? 16 : 8);
		col = cur_i % w;
		left_col = (col == 0);
		right_col = (col == w - 1);
		a_a = cur_i - 1;
		a_b = cur_i - w;
		a_c = a_b + 1;
		a_d = a_b - 1;
		av_a = a_a >= 0 && !left_col;
		av_b = a_b >= 0;
		av_c = a_c >= 0 && a_c <= cur_i && !right_col;
		av_d = a_d >= 0 && !left_col;
		x_in = xs >= 0 && xs < mw;
		y_in = ys >= 0 && ys < mh;

		r.kind = nld_pkg::KIND_NONE;
		r.avail = 1'b0;
		sel_addr = 0;
		// Pick the covering macroblock from the location quadrant
		if (xs < 0 && ys < 0) begin
			r.kind = nld_pkg::KIND_D; r.avail = av_d; sel_addr = a_d;
		end else if (xs < 0 && y_in) begin
			r.kind = nld_pkg::KIND_A; r.avail = av_a; sel_addr = a_a;
		end else if (x_in && ys < 0) begin
			r.kind = nld_pkg::KIND_B; r.avail = av_b; sel_addr = a_b;
		end else if (x_in && y_in) begin
			r.kind = nld_pkg::KIND_CUR; r.avail = 1'b1; sel_addr = cur_i;
		end else if (xs >= mw && ys < 0) begin
			r.kind = nld_pkg::KIND_C; r.avail = av_c; sel_addr = a_c;
		end
		if (cur_i >= nld_pkg::MAX_FRAME_MBS) begin
			r.kind = nld_pkg::KIND_NONE;
			r.avail = 1'b0;
		end
		r.addr = r.avail ? nld_pkg::ADDR_W'(sel_addr) : '0;
		r.wx = 4'(xs & (mw - 1));
		r.wy = 4'(ys & (mh - 1));
		return r;
	endfunction

	// Present one item, hold it until accepted, then queue its expected result
	task automatic send_item(input logic [nld_pkg::CUR_W-1:0] cur,
			input logic signed [nld_pkg::LOC_W-1:0] x,
			input logic signed [nld_pkg::LOC_W-1:0] y, input logic luma, input bit typed,
			input nb_result_t typed_res);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_mb_addr <= cur;
		loc_x <= x;
		loc_y <= y;
		is_luma <= luma;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		neighbour_q.push_back(typed ? typed_res : derive_neighbour(cur, x, y, luma, shadow_cfg));
		items_sent++;
	endtask

	// Write one register, read it back, and track it in the shadow copy
	task automatic write_reg(input nld_pkg::reg_idx_t idx,
			input logic [nld_pkg::APB_DATA_W-1:0] val);
		logic [nld_pkg::APB_DATA_W-1:0] mask;
		mask = (idx == nld_pkg::REG_PIC_WIDTH) ? nld_pkg::APB_DATA_W'(9'h1FF)
			: nld_pkg::APB_DATA_W'(5'h1F);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= nld_pkg::APB_ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== (val & mask))
			$error("readback %s expected %0h actual %0h", idx.name(), val & mask, prdata & mask);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			nld_pkg::REG_PIC_WIDTH: shadow_cfg.pic_width_mbs = val[nld_pkg::PICW_W-1:0];
			nld_pkg::REG_CHROMA_W:  shadow_cfg.chroma_mb_width = val[nld_pkg::CHRW_W-1:0];
			default:                shadow_cfg.chroma_mb_height = val[nld_pkg::CHRW_W-1:0];
		endcase
	endtask

	// Wait until every expected result is back, then let the pipeline empty
	task automatic settle();
		while (neighbour_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	// Draw a location, mostly in the nominal -1..16 range
	function automatic logic signed [nld_pkg::LOC_W-1:0] pick_loc();
		int v;
		if ($urandom_range(0, 99) < 85)
			v = int'($urandom_range(0, 17)) - 1;
		else
			v = $urandom_range(0, 63);
		return nld_pkg::LOC_W'(v);
	endfunction

	// Draw an address biased to the top rows and to the edge columns
	function automatic logic [nld_pkg::CUR_W-1:0] pick_addr(input int w);
		int k, v;
		case ($urandom_range(0, 9)) inside
			[0:4]: v = $urandom_range(0, (4 * w + 3 > 65535) ? 65535 : 4 * w + 3);
			[5:6]: begin
				k = $urandom_range(0, 65535 / w - 1);
				v = k * w + ($urandom_range(0, 1) ? w - 1 : 0);
			end
			default: v = $urandom_range(0, 65535);
		endcase
		return nld_pkg::CUR_W'(v);
	endfunction

	// Random stall bursts on the result side
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
			stall_left = $urandom_range(1, 7);
		out_stall <= (stall_left > 0);
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		nb_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (neighbour_q.size() == 0) begin
				$error("result item arrived with nothing expected");
				mismatches++;
			end else begin
				want = neighbour_q.pop_front();
				if (nb_available !== want.avail) begin
					$error("nb_available expected %0d actual %0d", want.avail, nb_available);
					mismatches++;
				end
				if (nb_addr !== want.addr) begin
					$error("nb_addr expected %0d actual %0d", want.addr, nb_addr);
					mismatches++;
				end
				if (nb_kind !== want.kind) begin
					$error("nb_kind expected %0d actual %0d", want.kind, nb_kind);
					mismatches++;
				end
				if (wrapped_x !== want.wx) begin
					$error("wrapped_x expected %0d actual %0d", want.wx, wrapped_x);
					mismatches++;
				end
				if (wrapped_y !== want.wy) begin
					$error("wrapped_y expected %0d actual %0d", want.wy, wrapped_y);
					mismatches++;
				end
			end
		end
	end

	// Abort when neither channel nor the register port moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", neighbour_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// Reset, hand-picked lookups, then random lookups under each register setting
	initial begin
		nb_result_t    res;
		nld_pkg::cfg_t phase_cfg;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cur_mb_addr <= '0;
		loc_x <= '0;
		loc_y <= '0;
		is_luma <= 1'b0;
		shadow_cfg = '{nld_pkg::PIC_WIDTH_RST, nld_pkg::CHROMA_RST, nld_pkg::CHROMA_RST};
		idle_pct = 15;
		stall_left = 0;
		quiet_cycles = 0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the hand-picked table
		foreach (probe_rows[i]) begin
			res.avail = probe_rows[i].avail;
			res.addr = nld_pkg::ADDR_W'(probe_rows[i].addr);
			res.kind = probe_rows[i].kind;
			res.wx = 4'(probe_rows[i].wx);
			res.wy = 4'(probe_rows[i].wy);
			send_item(nld_pkg::CUR_W'(probe_rows[i].cur), nld_pkg::LOC_W'(probe_rows[i].x),
				nld_pkg::LOC_W'(probe_rows[i].y), probe_rows[i].luma,
				probe_rows[i].typed, res);
		end

		// Random phases: fixed extremes first, then random settings, quiet at the end
		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			settle();
			case (p)
				0: phase_cfg = '{9'd11, 5'd16, 5'd16};
				1: phase_cfg = '{9'd256, 5'd8, 5'd16};
				2: phase_cfg = '{9'd0, 5'd31, 5'd7};
				3: phase_cfg = '{9'd511, 5'd16, 5'd8};
				4: phase_cfg = '{9'd257, 5'd0, 5'd24};
				5: phase_cfg = '{9'd1, 5'd16, 5'd16};
				default: phase_cfg = '{nld_pkg::PICW_W'($urandom_range(0, 511)),
					nld_pkg::CHRW_W'($urandom_range(0, 31)),
					nld_pkg::CHRW_W'($urandom_range(0, 31))};
			endcase
			idle_pct = (p == 2 || p == PHASES - 1) ? 0 : 20;
			write_reg(nld_pkg::REG_PIC_WIDTH,
				nld_pkg::APB_DATA_W'(phase_cfg.pic_width_mbs));
			write_reg(nld_pkg::REG_CHROMA_W,
				nld_pkg::APB_DATA_W'(phase_cfg.chroma_mb_width));
			write_reg(nld_pkg::REG_CHROMA_H,
				nld_pkg::APB_DATA_W'(phase_cfg.chroma_mb_height));
			settings_used++;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(pick_addr(eff_width(shadow_cfg)), pick_loc(), pick_loc(),
					1'($urandom_range(0, 1)), 1'b0, res);
		end

		in_valid <= 1'b0;
		settle();
		$display("covered %0d lookups under %0d register settings", items_sent, settings_used);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && neighbour_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
